// ----- hdl/tgp_pkg.sv -----
package tgp_pkg;

	localparam int IdxW = 10;
	localparam int ValW = 16;
	localparam int SumW = 20;

	typedef logic [1:0] action_t;
	typedef logic [IdxW-1:0] idx_t;
	typedef logic signed [ValW-1:0] value_t;
	typedef logic signed [SumW-1:0] sum_t;

	localparam action_t ACT_WRITE = 2'd0;
	localparam action_t ACT_MAX   = 2'd1;
	localparam action_t ACT_SUM   = 2'd2;

endpackage

// ----- hdl/tgp_ram.sv -----
module tgp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 720
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/tower_grid_peak_3x3_sum.sv -----
// write item: stored in the cycle it is accepted, no result
// sum around given tower: index split (S_DIV, S_MOD), window reads (S_WIN), S_WLAST; off the grid: sum zero
// sum around peak: a scan read of every tower through the store's single read port, then the window sum around the peak
// one query in flight at a time; the next item is taken while the result waits in its register
// reset: a clearing pass (S_CLEAR) writes zero to every
// tower, in_ready stays low until it ends
module tower_grid_peak_3x3_sum #(
	parameter int ETA_BINS = 12,
	parameter int PHI_BINS = 60
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  tgp_pkg::action_t      action,
	input  tgp_pkg::idx_t         tower_index,
	input  tgp_pkg::value_t       tower_value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output tgp_pkg::sum_t         window_sum,
	output tgp_pkg::idx_t         centre_tower
);

	localparam int NumTowers = ETA_BINS * PHI_BINS;
	localparam int AW = $clog2(NumTowers);
	localparam int EW = $clog2(ETA_BINS);
	localparam int PW = $clog2(PHI_BINS);

	// phi = index / ETA_BINS by reciprocal multiplication
	localparam int DivShift = tgp_pkg::IdxW + 7;
	localparam int DivMulW  = DivShift - 1;
	localparam int ProdW    = tgp_pkg::IdxW + DivMulW;
	localparam int DivMul   = ((1 << DivShift) + ETA_BINS - 1) / ETA_BINS;

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_DIV   = 4'd2;
	localparam logic [3:0] S_SCAN  = 4'd3;
	localparam logic [3:0] S_SLAST = 4'd4;
	localparam logic [3:0] S_WIN   = 4'd5;
	localparam logic [3:0] S_WLAST = 4'd6;
	localparam logic [3:0] S_DONE  = 4'd7;
	localparam logic [3:0] S_MOD   = 4'd8;

	logic [3:0]          state_q;
	logic [AW-1:0]       addr_q;
	logic [EW-1:0]       sc_eta_q;
	logic [PW-1:0]       sc_phi_q;
	logic [EW-1:0]       cen_eta_q;
	logic [PW-1:0]       cen_phi_q;
	tgp_pkg::value_t     best_q;
	tgp_pkg::idx_t       rem_q;
	logic [1:0]          de_q;
	logic [1:0]          dp_q;
	tgp_pkg::idx_t       centre_q;
	tgp_pkg::sum_t       acc_q;
	logic                cmp_s1;
	logic                acc_s1;
	logic [AW-1:0]       addr_s1;
	logic [EW-1:0]       eta_s1;
	logic [PW-1:0]       phi_s1;
	logic                out_valid_q;
	tgp_pkg::sum_t       window_sum_q;
	tgp_pkg::idx_t       centre_tower_q;

	logic                accept;
	logic                in_range;
	logic [EW:0]         eta_ext;
	logic                e_ok;
	logic [EW-1:0]       e_val;
	logic [PW-1:0]       p_val;
	logic [AW-1:0]       win_addr;
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [15:0]         ram_wdata;
	logic [AW-1:0]       ram_raddr;
	logic [15:0]         ram_rdata;
	tgp_pkg::value_t     rd_val;
	logic                out_load;
	logic [ProdW-1:0]    div_prod;
	logic [PW-1:0]       div_quo;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign in_range = {22'd0, tower_index} < 32'(NumTowers);

	assign div_prod = ProdW'(rem_q) * ProdW'(DivMul);
	assign div_quo  = PW'(div_prod[ProdW-1:DivShift]);

	// window neighbour address, eta clipped and phi wrapped
	assign eta_ext  = {1'b0, cen_eta_q} + (EW+1)'(de_q);
	assign e_ok     = (eta_ext != '0) && (eta_ext <= (EW+1)'(ETA_BINS));
	assign e_val    = EW'(eta_ext - (EW+1)'(1));

	always_comb begin
		p_val = cen_phi_q;
		case (dp_q)
			2'd0: p_val = (cen_phi_q == '0) ? PW'(PHI_BINS - 1) : PW'(cen_phi_q - PW'(1));
			2'd2: p_val = (cen_phi_q == PW'(PHI_BINS - 1)) ? '0 : PW'(cen_phi_q + PW'(1));
			default: p_val = cen_phi_q;
		endcase
	end

	assign win_addr = AW'(AW'(e_val) + AW'(ETA_BINS) * AW'(p_val));

	assign ram_we    = (state_q == S_CLEAR) || (accept && action == tgp_pkg::ACT_WRITE && in_range);
	assign ram_waddr = (state_q == S_CLEAR) ? addr_q : AW'(tower_index);
	assign ram_wdata = (state_q == S_CLEAR) ? 16'd0 : tower_value;
	assign ram_raddr = (state_q == S_WIN) ? win_addr : addr_q;
	assign rd_val    = $signed(ram_rdata);

	tgp_ram #(
		.WIDTH(16),
		.DEPTH(NumTowers)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			addr_q         <= '0;
			sc_eta_q       <= '0;
			sc_phi_q       <= '0;
			cen_eta_q      <= '0;
			cen_phi_q      <= '0;
			best_q         <= '0;
			rem_q          <= '0;
			de_q           <= '0;
			dp_q           <= '0;
			centre_q       <= '0;
			acc_q          <= '0;
			cmp_s1         <= 1'b0;
			acc_s1         <= 1'b0;
			addr_s1        <= '0;
			eta_s1         <= '0;
			phi_s1         <= '0;
			out_valid_q    <= 1'b0;
			window_sum_q   <= '0;
			centre_tower_q <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (addr_q == AW'(NumTowers - 1)) begin
						addr_q  <= '0;
						state_q <= S_IDLE;
					end else begin
						addr_q <= AW'(addr_q + AW'(1));
					end
				end
				S_IDLE: begin
					if (accept) begin
						unique case (action)
							tgp_pkg::ACT_MAX: begin
								addr_q    <= '0;
								sc_eta_q  <= '0;
								sc_phi_q  <= '0;
								best_q    <= '0;
								cen_eta_q <= '0;
								cen_phi_q <= '0;
								centre_q  <= '0;
								state_q   <= S_SCAN;
							end
							tgp_pkg::ACT_SUM: begin
								centre_q <= tower_index;
								if (in_range) begin
									rem_q   <= tower_index;
									state_q <= S_DIV;
								end else begin
									acc_q   <= '0;
									state_q <= S_DONE;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_DIV: begin
					cen_phi_q <= div_quo;
					state_q   <= S_MOD;
				end
				S_MOD: begin
					cen_eta_q <= EW'(rem_q - tgp_pkg::IdxW'(ETA_BINS) * tgp_pkg::IdxW'(cen_phi_q));
					de_q      <= '0;
					dp_q      <= '0;
					acc_q     <= '0;
					state_q   <= S_WIN;
				end
				S_SCAN: begin
					addr_q <= AW'(addr_q + AW'(1));
					if (sc_eta_q == EW'(ETA_BINS - 1)) begin
						sc_eta_q <= '0;
						sc_phi_q <= PW'(sc_phi_q + PW'(1));
					end else begin
						sc_eta_q <= EW'(sc_eta_q + EW'(1));
					end
					if (addr_q == AW'(NumTowers - 1)) begin
						state_q <= S_SLAST;
					end
				end
				S_SLAST: begin
					de_q    <= '0;
					dp_q    <= '0;
					acc_q   <= '0;
					state_q <= S_WIN;
				end
				S_WIN: begin
					if (dp_q == 2'd2) begin
						dp_q <= '0;
						if (de_q == 2'd2) begin
							state_q <= S_WLAST;
						end else begin
							de_q <= de_q + 2'd1;
						end
					end else begin
						dp_q <= dp_q + 2'd1;
					end
				end
				S_WLAST: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// read data stage: peak compare during the scan, window accumulate after
			cmp_s1  <= (state_q == S_SCAN);
			acc_s1  <= (state_q == S_WIN) && e_ok;
			addr_s1 <= addr_q;
			eta_s1  <= sc_eta_q;
			phi_s1  <= sc_phi_q;

			if (cmp_s1 && (rd_val > best_q)) begin
				best_q    <= rd_val;
				centre_q  <= tgp_pkg::IdxW'(addr_s1);
				cen_eta_q <= eta_s1;
				cen_phi_q <= phi_s1;
			end
			if (acc_s1) begin
				acc_q <= acc_q + {{(tgp_pkg::SumW - tgp_pkg::ValW){rd_val[15]}}, rd_val};
			end

			if (out_load) begin
				out_valid_q    <= 1'b1;
				window_sum_q   <= acc_q;
				centre_tower_q <= centre_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign window_sum   = window_sum_q;
	assign centre_tower = centre_tower_q;

endmodule

// ----- hdl/tgp_checker.sv -----
module tgp_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  tgp_pkg::action_t action,
	input  logic             out_valid,
	input  logic             out_ready,
	input  tgp_pkg::sum_t    window_sum,
	input  tgp_pkg::idx_t    centre_tower
);

	// result holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(window_sum) && $stable(centre_tower))
		else $error("result changed or dropped while stalled");

	// the input stays closed while reset is held
	a_clear_closed: assert property (@(posedge clk)
		!arst_n && $past(!arst_n) |-> !in_ready)
		else $error("input open during reset");

	// a write item never raises a result
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && action == tgp_pkg::ACT_WRITE && !out_valid |=> !out_valid)
		else $error("result after a write item");

	// a query closes the input once it is taken
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (action == tgp_pkg::ACT_MAX || action == tgp_pkg::ACT_SUM)
		|=> !in_ready)
		else $error("item taken while a query runs");

endmodule

bind tower_grid_peak_3x3_sum tgp_checker u_tgp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.action      (action),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.window_sum  (window_sum),
	.centre_tower(centre_tower)
);

// ----- sim/tower_grid_peak_3x3_sum_tb.sv -----
`timescale 1ns / 1ps

module tower_grid_peak_3x3_sum_tb;

	localparam int GRID_ETA = 12;
	localparam int GRID_PHI = 60;
	localparam int TOWERS = GRID_ETA * GRID_PHI;
	localparam int ITEMS = 450;
	localparam int SETTLE_CYCLES = 800;
	localparam int LIMIT = 3_000_000;
	localparam tgp_pkg::action_t ACT_NONE = 2'd3;

	typedef struct packed {
		tgp_pkg::sum_t sum;
		tgp_pkg::idx_t centre;
	} cluster_t;

	typedef struct packed {
		tgp_pkg::action_t act;
		tgp_pkg::idx_t idx;
		tgp_pkg::value_t val;
		logic typed;
		tgp_pkg::sum_t sum;
		tgp_pkg::idx_t centre;
	} step_t;

	localparam int N_DIRECTED = 23;
	localparam step_t DIRECTED [N_DIRECTED] = '{
		'{tgp_pkg::ACT_MAX,   10'd0,    16'h0000, 1'b1, 20'd0, 10'd0},
		'{tgp_pkg::ACT_SUM,   10'd719,  16'h0000, 1'b1, 20'd0, 10'd719},
		'{tgp_pkg::ACT_SUM,   10'd1023, 16'hffff, 1'b1, 20'd0, 10'd1023},
		'{tgp_pkg::ACT_SUM,   10'd720,  16'h0000, 1'b1, 20'd0, 10'd720},
		'{ACT_NONE,           10'd1023, 16'hffff, 1'b0, 20'd0, 10'd0},
		'{tgp_pkg::ACT_WRITE, 10'd1023, 16'h7fff, 1'b0, 20'd0, 10'd0},
		'{tgp_pkg::ACT_WRITE, 10'd720,  16'h7fff, 1'b0, 20'd0, 10'd0},
		'{tgp_pkg::ACT_MAX,   10'd0,    16'h0000, 1'b1, 20'd0, 10'd0},
		'{tgp_pkg::ACT_WRITE, 10'd0,    16'h7fff, 1'b0, 20'd0, 10'd0},
		'{tgp_pkg::ACT_WRITE, 10'd11,   16'h8000, 1'b0, 20'd0, 10'd0},
		'{tgp_pkg::ACT_WRITE, 10'd708,  16'h7fff, 1'b0, 20'd0, 10'd0},
		'{tgp_pkg::ACT_WRITE, 10'd719,  16'h8000, 1'b0, 20'd0, 10'd0},
		'{tgp_pkg::ACT_SUM,   10'd0,    16'h0000, 1'b0, 20'd0, 10'd0},
		'{tgp_pkg::ACT_MAX,   10'd0,    16'h0000, 1'b0, 20'd0, 10'd0},
		'{tgp_pkg::ACT_SUM,   10'd719,  16'h0000, 1'b0, 20'd0, 10'd0},
		'{tgp_pkg::ACT_SUM,   10'd11,   16'h0000, 1'b0, 20'd0, 10'd0},
		'{tgp_pkg::ACT_WRITE, 10'd0,    16'hfffb, 1'b0, 20'd0, 10'd0},
		'{tgp_pkg::ACT_WRITE, 10'd708,  16'hffff, 1'b0, 20'd0, 10'd0},
		'{tgp_pkg::ACT_MAX,   10'd0,    16'h0000, 1'b0, 20'd0, 10'd0},
		'{tgp_pkg::ACT_WRITE, 10'd365,  16'h0001, 1'b0, 20'd0, 10'd0},
		'{tgp_pkg::ACT_MAX,   10'd0,    16'h0000, 1'b0, 20'd0, 10'd0},
		'{ACT_NONE,           10'd0,    16'h0000, 1'b0, 20'd0, 10'd0},
		'{tgp_pkg::ACT_SUM,   10'd708,  16'h0000, 1'b0, 20'd0, 10'd0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	tgp_pkg::action_t action = tgp_pkg::ACT_WRITE;
	tgp_pkg::idx_t tower_index = '0;
	tgp_pkg::value_t tower_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	tgp_pkg::sum_t window_sum;
	tgp_pkg::idx_t centre_tower;

	tgp_pkg::value_t grid [TOWERS];
	cluster_t pending_q [$];
	cluster_t want;
	int n_items = 0;
	int n_bad = 0;
	int cycles = 0;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;

	tower_grid_peak_3x3_sum #(
		.ETA_BINS(GRID_ETA),
		.PHI_BINS(GRID_PHI)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.tower_index(tower_index),
		.tower_value(tower_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.window_sum(window_sum),
		.centre_tower(centre_tower)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic tgp_pkg::sum_t cluster_sum(input int c);
		int eta, phi, acc, de, dp, p;
		eta = c % GRID_ETA;
		phi = c / GRID_ETA;
		acc = 0;
		for (de = -1; de <= 1; de++) begin
			if (eta + de >= 0 && eta + de < GRID_ETA) begin
				for (dp = -1; dp <= 1; dp++) begin
					p = (phi + dp + GRID_PHI) % GRID_PHI;
					acc += int'(grid[eta + de + GRID_ETA * p]);
				end
			end
		end
		return tgp_pkg::sum_t'(acc);
	endfunction

	function automatic bit model_step(input tgp_pkg::action_t a, input tgp_pkg::idx_t i,
			input tgp_pkg::value_t v, output cluster_t res);
		int best, peak, k;
		res = '0;
		case (a)
			tgp_pkg::ACT_WRITE: begin
				if (i < TOWERS)
					grid[i] = v;
				return 1'b0;
			end
			tgp_pkg::ACT_MAX: begin
				best = 0;
				peak = 0;
				for (k = 0; k < TOWERS; k++) begin
					if (int'(grid[k]) > best) begin
						best = int'(grid[k]);
						peak = k;
					end
				end
				res.sum = cluster_sum(peak);
				res.centre = tgp_pkg::idx_t'(peak);
				return 1'b1;
			end
			tgp_pkg::ACT_SUM: begin
				res.sum = (i < TOWERS) ? cluster_sum(int'(i)) : tgp_pkg::sum_t'(0);
				res.centre = i;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic send_item(input tgp_pkg::action_t a, input tgp_pkg::idx_t i,
			input tgp_pkg::value_t v, input logic typed, input cluster_t typed_res);
		cluster_t res;
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action <= a;
		tower_index <= i;
		tower_value <= v;
		do @(posedge clk); while (!in_ready);
		if (model_step(a, i, v, res))
			pending_q.push_back(typed ? typed_res : res);
		n_items++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_q.size() != 0)
			@(negedge clk);
	endtask

	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("unexpected result: window_sum %0d centre_tower %0d",
						window_sum, centre_tower);
			end else begin
				want = pending_q.pop_front();
				if (window_sum !== want.sum) begin
					n_bad++;
					if (n_bad <= 10)
						$display("window_sum mismatch (centre %0d): expected %0d got %0d",
							want.centre, want.sum, window_sum);
				end
				if (centre_tower !== want.centre) begin
					n_bad++;
					if (n_bad <= 10)
						$display("centre_tower mismatch: expected %0d got %0d",
							want.centre, centre_tower);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin : stim
		int n, r, c, eta, phi, de, dp, e, p, mode, phase, cur_phase;
		tgp_pkg::value_t cv;
		for (n = 0; n < TOWERS; n++)
			grid[n] = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (n = 0; n < N_DIRECTED; n++)
			send_item(DIRECTED[n].act, DIRECTED[n].idx, DIRECTED[n].val, DIRECTED[n].typed,
				cluster_t'{DIRECTED[n].sum, DIRECTED[n].centre});

		cur_phase = 0;
		while (n_items < ITEMS) begin
			phase = (n_items * 4) / ITEMS;
			if (phase > 3)
				phase = 3;
			if (phase != cur_phase) begin
				// hold off until the block has handed back everything
				drain_results();
				cur_phase = phase;
				src_idle_pct = (phase == 1) ? 87 : (phase == 3) ? 9 : 0;
				sink_stall_pct = (phase == 2) ? 87 : (phase == 3) ? 9 : 0;
			end
			r = $urandom_range(0, 99);
			if (r < 55) begin
				cv = tgp_pkg::value_t'($urandom_range(0, 65535));
				if ($urandom_range(0, 7) == 0)
					cv = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
				send_item(tgp_pkg::ACT_WRITE, tgp_pkg::idx_t'($urandom_range(0, TOWERS - 1)),
					cv, 1'b0, '0);
			end else if (r < 65) begin
				// fill a whole window, then query it
				c = $urandom_range(0, TOWERS - 1);
				eta = c % GRID_ETA;
				phi = c / GRID_ETA;
				mode = $urandom_range(0, 2);
				for (de = -1; de <= 1; de++) begin
					e = eta + de;
					if (e >= 0 && e < GRID_ETA) begin
						for (dp = -1; dp <= 1; dp++) begin
							p = (phi + dp + GRID_PHI) % GRID_PHI;
							cv = (mode == 0) ? 16'sh7fff : (mode == 1) ? 16'sh8000 :
								tgp_pkg::value_t'($urandom_range(0, 65535));
							send_item(tgp_pkg::ACT_WRITE, tgp_pkg::idx_t'(e + GRID_ETA * p),
								cv, 1'b0, '0);
						end
					end
				end
				send_item(tgp_pkg::ACT_SUM, tgp_pkg::idx_t'(c),
					tgp_pkg::value_t'($urandom_range(0, 65535)), 1'b0, '0);
				if ($urandom_range(0, 1))
					send_item(tgp_pkg::ACT_MAX, tgp_pkg::idx_t'($urandom_range(0, 1023)),
						tgp_pkg::value_t'($urandom_range(0, 65535)), 1'b0, '0);
			end else if (r < 83) begin
				c = ($urandom_range(0, 9) == 0) ? $urandom_range(TOWERS, 1023) :
					$urandom_range(0, TOWERS - 1);
				send_item(tgp_pkg::ACT_SUM, tgp_pkg::idx_t'(c),
					tgp_pkg::value_t'($urandom_range(0, 65535)), 1'b0, '0);
			end else if (r < 91) begin
				send_item(tgp_pkg::ACT_MAX, tgp_pkg::idx_t'($urandom_range(0, 1023)),
					tgp_pkg::value_t'($urandom_range(0, 65535)), 1'b0, '0);
			end else if (r < 96) begin
				send_item(ACT_NONE, tgp_pkg::idx_t'($urandom_range(0, 1023)),
					tgp_pkg::value_t'($urandom_range(0, 65535)), 1'b0, '0);
			end else begin
				send_item(tgp_pkg::ACT_WRITE, tgp_pkg::idx_t'($urandom_range(TOWERS, 1023)),
					tgp_pkg::value_t'($urandom_range(0, 65535)), 1'b0, '0);
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (n_bad == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/tgp_pkg.sv
hdl/tgp_ram.sv
hdl/tower_grid_peak_3x3_sum.sv
hdl/tgp_checker.sv
sim/tower_grid_peak_3x3_sum_tb.sv
